>>> design/ecg_beat_rate_detector_defines.svh
// Assertion macros shared by the beat rate detector checker.
// No dependencies; include by bare file name.
`ifndef ECG_BEAT_RATE_DETECTOR_DEFINES_SVH
`define ECG_BEAT_RATE_DETECTOR_DEFINES_SVH

// Property checked only outside reset.
`define ECGBR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ECGBR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ecgbr_pkg.sv
// Types and constants of the ECG beat rate detector.
// No dependencies; imported by every module of the block.
package ecgbr_pkg;

    typedef struct packed {
        logic [11:0] sample;
        logic [31:0] time_ms;
    } sample_item_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] beats_per_minute;
    } result_item_t;

    // Work handed from the classifier to the rate divider.
    typedef struct packed {
        logic        accepted;
        logic        zero_rate;
        logic [15:0] divisor;
    } rate_job_t;

    typedef enum logic [1:0] {
        REG_UPPER   = 2'd0,
        REG_LOWER   = 2'd1,
        REG_LATENCY = 2'd2
    } cfg_reg_t;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [15:0] LATENCY_RESET = 16'd20;
    localparam int          DIV_STEPS     = 16;

endpackage

>>> design/ecgbr_front.sv
// Front end: configuration registers, latency gate and beat hysteresis.
// Depends on ecgbr_pkg; pushes one rate job per sample transaction, rejected ones included.
module ecgbr_front
    import ecgbr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [15:0]  wr_data,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    input  logic         queue_full,
    output logic         push,
    output rate_job_t    push_job
);

    logic [11:0] upper_reg;
    logic [11:0] lower_reg;
    logic [15:0] latency_reg;
    logic [31:0] last_accept_reg;
    logic        in_beat_reg;
    logic        first_seen_reg;
    logic [31:0] prev_beat_reg;
    logic [31:0] interval_reg;

    logic [31:0] gap;
    logic        pass;
    logic        beat_start;
    logic        below_lower;
    logic [31:0] interval_next;
    logic        in_beat_next;

    always_comb
    begin
        gap           = sample_item.time_ms - last_accept_reg;
        pass          = gap > {16'd0, latency_reg};
        beat_start    = pass && (sample_item.sample > upper_reg) && !in_beat_reg;
        below_lower   = sample_item.sample < lower_reg;
        interval_next = interval_reg;
        if (beat_start && first_seen_reg)
        begin
            interval_next = sample_item.time_ms - prev_beat_reg;
        end
        // Leading edge first, then re-arm on the same sample.
        in_beat_next = in_beat_reg;
        if (pass)
        begin
            in_beat_next = (in_beat_reg || beat_start) && !below_lower;
        end
    end

    assign sample_stall = queue_full;
    assign push         = sample_valid && !queue_full;

    always_comb
    begin
        push_job.accepted  = pass;
        push_job.zero_rate = !pass || (interval_next == 32'd0)
                             || (interval_next[31:16] != 16'd0);
        push_job.divisor   = interval_next[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg       <= '0;
            lower_reg       <= '0;
            latency_reg     <= LATENCY_RESET;
            last_accept_reg <= '0;
            in_beat_reg     <= 1'b0;
            first_seen_reg  <= 1'b0;
            prev_beat_reg   <= '0;
            interval_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_UPPER:   upper_reg   <= wr_data[11:0];
                    REG_LOWER:   lower_reg   <= wr_data[11:0];
                    REG_LATENCY: latency_reg <= wr_data;
                    default:     ;
                endcase
            end
            if (push && pass)
            begin
                last_accept_reg <= sample_item.time_ms;
                in_beat_reg     <= in_beat_next;
                interval_reg    <= interval_next;
                if (beat_start)
                begin
                    first_seen_reg <= 1'b1;
                    prev_beat_reg  <= sample_item.time_ms;
                end
            end
        end
    end

endmodule

>>> design/ecgbr_queue.sv
// Short job queue between the classifier and the rate divider.
// Depends on ecgbr_pkg for the job type.
module ecgbr_queue
    import ecgbr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rate_job_t push_job,
    output logic      full,
    input  logic      pop,
    output rate_job_t pop_job,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rate_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == FULL_CNT;
    assign empty   = count_reg == '0;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/ecgbr_back.sv
// Back end: bit-serial divider for 60000 / interval and the result register.
// Depends on ecgbr_pkg; drains rate jobs from the queue one at a time.
module ecgbr_back
    import ecgbr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         empty,
    input  rate_job_t    pop_job,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'(DIV_STEPS - 1);

    state_t       state_reg;
    logic [15:0]  quo_reg;
    logic [15:0]  rem_reg;
    logic [15:0]  divisor_reg;
    logic [3:0]   step_reg;
    logic         acc_reg;
    logic         result_valid_reg;
    result_item_t result_item_reg;

    logic [16:0]  trial;
    logic [16:0]  diff;
    logic         fits;
    logic         out_free;

    always_comb
    begin
        trial = {rem_reg, quo_reg[15]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = trial >= {1'b0, divisor_reg};
    end

    assign out_free     = !result_valid_reg || !result_stall;
    assign pop          = (state_reg == S_IDLE) && !empty;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_item_reg  <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            divisor_reg      <= '0;
            step_reg         <= '0;
            acc_reg          <= 1'b0;
        end
        else
        begin
            // Load a new result, or drop the old one once the transaction completes.
            if ((state_reg == S_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        acc_reg     <= pop_job.accepted;
                        rem_reg     <= '0;
                        divisor_reg <= pop_job.divisor;
                        step_reg    <= LAST_STEP;
                        if (pop_job.zero_rate)
                        begin
                            quo_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            quo_reg   <= MS_PER_MINUTE;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // Shift one dividend bit in, quotient bit out.
                    rem_reg  <= fits ? diff[15:0] : trial[15:0];
                    quo_reg  <= {quo_reg[14:0], fits};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_item_reg.accepted         <= acc_reg;
                        result_item_reg.beats_per_minute <= quo_reg;
                        state_reg                        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/ecg_beat_rate_detector.sv
// Channel   | Direction | Handshake                   | Payload
// sample    | in        | sample_valid / sample_stall | sample_item_t (sample, time_ms)
// result    | out       | result_valid / result_stall | result_item_t (accepted, bpm)
// config    | in        | wr_en                       | wr_index, wr_data
//
// The front end classifies each sample combinationally and takes it while the job queue has room.
// The back end handles one job at a time (queue pop, 16 divider steps, output load);
// rejected samples and zero rates skip the divider. It pops no new job until the
// last one's result is loaded, so the divider sets the sustained rate.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result holds the back end; the queue then fills and raises sample_stall.
module ecg_beat_rate_detector
    import ecgbr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [15:0]  wr_data,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    logic      push;
    rate_job_t push_job;
    logic      queue_full;
    logic      pop;
    rate_job_t pop_job;
    logic      queue_empty;

    ecgbr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    ecgbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    ecgbr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .pop_job      (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

>>> design/ecgbr_checker.sv
// Port-level checker for the ECG beat rate detector, bound to the top level.
// Depends on ecgbr_pkg and ecg_beat_rate_detector_defines.svh.
`include "ecg_beat_rate_detector_defines.svh"

module ecgbr_port_checks
    import ecgbr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    `ECGBR_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !result_valid,
        "result valid during reset")

    `ECGBR_ASSERT(a_stalled_result_holds, clk, rst_n,
        result_valid && result_stall |=> result_valid && $stable(result_item),
        "stalled result changed")

    `ECGBR_ASSERT(a_rejected_zero_rate, clk, rst_n,
        result_valid && !result_item.accepted |-> result_item.beats_per_minute == 16'd0,
        "rejected sample with nonzero rate")

    `ECGBR_ASSERT(a_rate_in_range, clk, rst_n,
        result_valid |-> result_item.beats_per_minute <= MS_PER_MINUTE,
        "rate above 60000")

endmodule

bind ecg_beat_rate_detector ecgbr_port_checks u_checker (.*);
